@@ hdl/cwmr_pkg.sv @@
// Shared types, constants and helper functions for the cigar walk block.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package cwmr_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 200;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Item kinds on the input stream.
  typedef enum logic [1:0] {
    OPC_START  = 2'd0,
    OPC_OP     = 2'd1,
    OPC_BASE   = 2'd2,
    OPC_FINISH = 2'd3
  } opc_t;

  // Cigar operation codes.
  localparam logic [3:0] CIG_M = 4'd0;
  localparam logic [3:0] CIG_I = 4'd1;
  localparam logic [3:0] CIG_D = 4'd2;
  localparam logic [3:0] CIG_N = 4'd3;
  localparam logic [3:0] CIG_S = 4'd4;
  localparam logic [3:0] CIG_H = 4'd5;

  // The single-base mismatch word is encoded as op in the low nibble and
  // length above it.
  localparam int unsigned OP_MASK   = 32'hf;
  localparam int unsigned X_WORD    = 24;
  localparam int unsigned OP_SHIFT  = 4;
  localparam int unsigned CASE_GAP  = 32;
  localparam logic [7:0]  BASE_N    = 8'h4e;
  localparam logic [3:0]  X_OP      = 4'(X_WORD & OP_MASK);
  localparam logic [27:0] X_LEN     = 28'(X_WORD >> OP_SHIFT);

  // Result kinds on the output stream.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // What the back end emits after the optional flushed match run.
  typedef enum logic [1:0] {
    SEC_NONE    = 2'd0,
    SEC_WORD    = 2'd1,
    SEC_X       = 2'd2,
    SEC_SUMMARY = 2'd3
  } sec_t;

  // One classified command from front to back.
  typedef struct packed {
    logic        clear;         // start of read: zero counters, load start
    logic        flush;         // emit an M word of flush_len first
    logic [27:0] flush_len;
    sec_t        sec;
    logic [3:0]  word_op;
    logic [30:0] value;         // start position or operation length
    logic        add_aligned;
    logic        add_query;
    logic        add_ref;
    logic        inc_gap;
    logic        inc_mismatch;
    logic        set_stop;
  } cmd_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] a);
    return (a == 16'hffff) ? a : a + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cwmr_front.sv @@
// Front end: accepts input items, tracks the match-run state of the walk
// and turns each item into one command. Depends on cwmr_pkg.
`default_nettype none

module cwmr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [1:0]         opcode,
  input  wire logic [30:0]        start_position,
  input  wire logic [3:0]         op_code,
  input  wire logic [27:0]        op_length,
  input  wire logic [7:0]         read_base,
  input  wire logic [7:0]         ref_base,
  output logic                    push,
  output cwmr_pkg::cmd_t          cmd
);

  logic [27:0] bases_left;
  logic [27:0] bases_left_next;
  logic [27:0] run_length;
  logic [27:0] run_length_next;
  logic        stopped;
  logic        stopped_next;
  logic [27:0] bases_dec;
  logic [27:0] run_inc;
  logic        mismatch;

  assign bases_dec = bases_left - 28'd1;
  assign run_inc   = run_length + 28'd1;
  // A base agrees with the reference directly, with its case-folded form,
  // or is an N.
  assign mismatch  = (read_base != ref_base) &&
                     (({1'b0, read_base} + 9'(cwmr_pkg::CASE_GAP)) != {1'b0, ref_base}) &&
                     (read_base != cwmr_pkg::BASE_N);

  always_comb begin
    cmd.clear        = 1'b0;
    cmd.flush        = 1'b0;
    cmd.flush_len    = run_length;
    cmd.sec          = cwmr_pkg::SEC_NONE;
    cmd.word_op      = op_code;
    cmd.value        = {3'b000, op_length};
    cmd.add_aligned  = 1'b0;
    cmd.add_query    = 1'b0;
    cmd.add_ref      = 1'b0;
    cmd.inc_gap      = 1'b0;
    cmd.inc_mismatch = 1'b0;
    cmd.set_stop     = 1'b0;
    bases_left_next  = bases_left;
    run_length_next  = run_length;
    stopped_next     = stopped;
    push             = accept;

    if (accept) begin
      unique case (cwmr_pkg::opc_t'(opcode))
        cwmr_pkg::OPC_START: begin
          cmd.clear       = 1'b1;
          cmd.value       = start_position;
          bases_left_next = '0;
          run_length_next = '0;
          stopped_next    = 1'b0;
        end
        cwmr_pkg::OPC_FINISH: begin
          cmd.flush       = (bases_left != '0) && (run_length != '0);
          cmd.sec         = cwmr_pkg::SEC_SUMMARY;
          bases_left_next = '0;
          run_length_next = '0;
        end
        cwmr_pkg::OPC_OP: begin
          if (!stopped) begin
            cmd.flush       = (bases_left != '0) && (run_length != '0);
            bases_left_next = '0;
            run_length_next = '0;
            if (op_code == cwmr_pkg::CIG_M) begin
              cmd.add_aligned = 1'b1;
              cmd.add_query   = 1'b1;
              cmd.add_ref     = 1'b1;
              bases_left_next = op_length;
            end else if (op_code != cwmr_pkg::CIG_H) begin
              cmd.sec = cwmr_pkg::SEC_WORD;
              if (op_code == cwmr_pkg::CIG_I) begin
                cmd.inc_gap     = 1'b1;
                cmd.add_aligned = 1'b1;
                cmd.add_query   = 1'b1;
              end else if (op_code == cwmr_pkg::CIG_D || op_code == cwmr_pkg::CIG_N) begin
                cmd.inc_gap = 1'b1;
                cmd.add_ref = 1'b1;
              end else if (op_code == cwmr_pkg::CIG_S) begin
                cmd.add_query = 1'b1;
              end else begin
                cmd.set_stop = 1'b1;
                stopped_next = 1'b1;
              end
            end
          end
        end
        cwmr_pkg::OPC_BASE: begin
          if (!stopped && bases_left != '0) begin
            bases_left_next = bases_dec;
            if (mismatch) begin
              cmd.inc_mismatch = 1'b1;
              cmd.flush        = (run_length != '0);
              cmd.sec          = cwmr_pkg::SEC_X;
              run_length_next  = '0;
            end else if (bases_dec == '0) begin
              cmd.flush       = 1'b1;
              cmd.flush_len   = run_inc;
              run_length_next = '0;
            end else begin
              run_length_next = run_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bases_left <= '0;
      run_length <= '0;
      stopped    <= 1'b0;
    end else begin
      bases_left <= bases_left_next;
      run_length <= run_length_next;
      stopped    <= stopped_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cwmr_queue.sv @@
// Small first-in first-out queue of commands between front and back.
// Depends on cwmr_pkg for the command type.
`default_nettype none

module cwmr_queue #(
  parameter int unsigned DEPTH = cwmr_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  cwmr_pkg::cmd_t          wr_data,
  output logic                    full,
  input  wire logic               pop,
  output cwmr_pkg::cmd_t          head,
  output logic                    head_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cwmr_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/cwmr_back.sv @@
// Back end: executes queued commands, keeps the saturating read counters and
// drives the registered result stream. Depends on cwmr_pkg.
`default_nettype none

module cwmr_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  cwmr_pkg::cmd_t                         head,
  input  wire logic                              head_valid,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [cwmr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  logic [30:0] read_start;
  logic [15:0] mismatches;
  logic [15:0] gaps;
  logic [31:0] aligned_bases;
  logic [31:0] query_used;
  logic [31:0] ref_used;
  logic        stopped;
  logic        phase;
  logic        phase_next;
  logic        out_free;
  logic        has_sec;
  logic        load;
  logic        o_kind;
  logic        o_last;
  logic [cwmr_pkg::OUT_TDATA_W-1:0] o_data;
  logic [31:0] add_len;
  logic [31:0] end_position;

  assign out_free     = !m_tvalid || m_tready;
  assign has_sec      = (head.sec != cwmr_pkg::SEC_NONE);
  assign add_len      = {4'h0, head.value[27:0]};
  assign end_position = cwmr_pkg::sat_add32({1'b0, read_start}, ref_used);

  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    phase_next = phase;
    o_kind     = cwmr_pkg::KIND_WORD;
    o_last     = 1'b1;
    o_data     = '0;
    if (head_valid) begin
      if (!head.flush && !has_sec) begin
        pop = 1'b1;
      end else if (out_free) begin
        load = 1'b1;
        if (head.flush && !phase) begin
          o_data = {168'd0, head.flush_len, cwmr_pkg::CIG_M};
          o_last = !has_sec;
          if (has_sec) begin
            phase_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          pop        = 1'b1;
          phase_next = 1'b0;
          unique case (head.sec)
            cwmr_pkg::SEC_WORD: begin
              o_data = {168'd0, head.value[27:0], head.word_op};
            end
            cwmr_pkg::SEC_X: begin
              o_data = {168'd0, cwmr_pkg::X_LEN, cwmr_pkg::X_OP};
            end
            cwmr_pkg::SEC_SUMMARY: begin
              o_kind = cwmr_pkg::KIND_SUMMARY;
              o_data = {7'd0, stopped, end_position, ref_used, query_used,
                        aligned_bases, gaps, mismatches, 32'd0};
            end
            default: begin
              o_data = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      phase         <= 1'b0;
      read_start    <= '0;
      mismatches    <= '0;
      gaps          <= '0;
      aligned_bases <= '0;
      query_used    <= '0;
      ref_used      <= '0;
      stopped       <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (head.clear) begin
          read_start    <= head.value;
          mismatches    <= '0;
          gaps          <= '0;
          aligned_bases <= '0;
          query_used    <= '0;
          ref_used      <= '0;
          stopped       <= 1'b0;
        end else begin
          if (head.add_aligned) begin
            aligned_bases <= cwmr_pkg::sat_add32(aligned_bases, add_len);
          end
          if (head.add_query) begin
            query_used <= cwmr_pkg::sat_add32(query_used, add_len);
          end
          if (head.add_ref) begin
            ref_used <= cwmr_pkg::sat_add32(ref_used, add_len);
          end
          if (head.inc_gap) begin
            gaps <= cwmr_pkg::sat_inc16(gaps);
          end
          if (head.inc_mismatch) begin
            mismatches <= cwmr_pkg::sat_inc16(mismatches);
          end
          if (head.set_stop) begin
            stopped <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= o_data;
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cigar_walk_mismatch_refine.sv @@
// Top level of the cigar walk with mismatch expansion: front end, command
// queue and back end. Depends on cwmr_pkg, cwmr_front, cwmr_queue, cwmr_back.
//
//   Channel   Direction  Handshake           Payload
//   --------  ---------  ------------------  ------------------------------------------
//   s_*       in         s_tvalid/s_tready   item kind in s_tuser, item fields in s_tdata
//   m_*       out        m_tvalid/m_tready   result kind in m_tuser, fields in m_tdata,
//                                            last result of an item on m_tlast
//
// The block takes one item per cycle while the queue has room. The front end
// classifies the item in the cycle it is accepted and writes one command into
// the queue. The back end retires one command per cycle unless the output
// stalls; a command with two results (a flushed match run followed by a
// mismatch word, an operation word or the read summary) holds it for both,
// and the queue absorbs those stalls. Results pass through the queue and then
// the output register. The synchronous reset clears the walk state, the
// counters, the queue and the output register; there is no clearing pass.
`default_nettype none

module cigar_walk_mismatch_refine #(
  parameter int unsigned QUEUE_DEPTH = cwmr_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata, lowest bit first: start_position(31), op_code(4), op_length(28),
  // read_base(8), ref_base(8), one zero pad bit.
  input  wire logic [cwmr_pkg::IN_TDATA_W-1:0]   s_tdata,
  // s_tuser: opcode(2).
  input  wire logic [1:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata, lowest bit first: word_op(4), word_length(28), mismatch_count(16),
  // gap_count(16), aligned_count(32), query_consumed(32), ref_consumed(32),
  // end_position(32), unsupported(1), seven zero pad bits.
  output logic [cwmr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // m_tuser: kind(1), 0 for a cigar word and 1 for the read summary.
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  logic           queue_full;
  logic           accept;
  logic           push;
  logic           pop;
  logic           head_valid;
  cwmr_pkg::cmd_t cmd;
  cwmr_pkg::cmd_t head;

  // The front end only waits for room in the queue, never for the output.
  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  cwmr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (s_tuser),
    .start_position (s_tdata[30:0]),
    .op_code        (s_tdata[34:31]),
    .op_length      (s_tdata[62:35]),
    .read_base      (s_tdata[70:63]),
    .ref_base       (s_tdata[78:71]),
    .push           (push),
    .cmd            (cmd)
  );

  cwmr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (cmd),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // The back end owns the counters so that a summary always sees the
  // updates of every command queued ahead of it.
  cwmr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire
